// File: rtl/core/assert_macros.svh
// Assertion helpers, clocked on the rising edge and held off while in reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define TEFR_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tefr assertion failed");

// Next-cycle implication.
`define TEFR_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tefr assertion failed");

`endif

// File: rtl/core/tefr_pkg.sv
package tefr_pkg;

  localparam int STAMP_W  = 32;
  localparam int MODULE_W = 16;
  localparam int INDEX_W  = 16;
  localparam int FLAGS_W  = 32;
  localparam int CFG_IDX_W = 1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_CRITICAL = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_IGNORE   = 1'b1;

  typedef enum logic [1:0] {
    OP_SET_CLR  = 2'd0,
    OP_DETAILS  = 2'd1,
    OP_CLR_ALL  = 2'd2,
    OP_SUMMARY  = 2'd3
  } op_t;

  typedef struct packed {
    logic [STAMP_W-1:0]  stamp;
    logic [MODULE_W-1:0] module_id;
    logic                state;
  } rec_t;

  typedef struct packed {
    logic rd_en;
    logic set_wr;
    logic clr_wr;
  } mem_ctl_t;

endpackage

// File: rtl/core/tefr_if.sv
interface tefr_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [15:0] error_index;
  logic        new_state;
  logic [15:0] caller_module;
  logic [31:0] current_time;

  modport source (output valid, operation, error_index, new_state, caller_module,
                  current_time, input ready);
  modport sink (input valid, operation, error_index, new_state, caller_module,
                current_time, output ready);
endinterface

interface tefr_out_if;
  logic        valid;
  logic        ready;
  logic        error_set;
  logic        current_state;
  logic [15:0] current_module;
  logic [31:0] current_time_stamp;
  logic [31:0] current_age;
  logic        previous_state;
  logic [15:0] previous_module;
  logic [31:0] previous_time_stamp;
  logic [31:0] previous_age;
  logic        is_enabled;
  logic        is_critical;
  logic [31:0] all_flags;

  modport source (output valid, error_set, current_state, current_module,
                  current_time_stamp, current_age, previous_state, previous_module,
                  previous_time_stamp, previous_age, is_enabled, is_critical,
                  all_flags, input ready);
  modport sink (input valid, error_set, current_state, current_module,
                current_time_stamp, current_age, previous_state, previous_module,
                previous_time_stamp, previous_age, is_enabled, is_critical,
                all_flags, output ready);
endinterface

// File: rtl/core/tefr_rec_mem.sv
module tefr_rec_mem #(
  parameter int DEPTH = 32,
  parameter int AW    = 5
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                wr_en,
  input  logic                rd_en,
  input  logic [AW-1:0]       addr,
  input  tefr_pkg::rec_t      wdata,
  output tefr_pkg::rec_t      rdata
);

  tefr_pkg::rec_t   mem_r [DEPTH];
  tefr_pkg::rec_t   rd_data_r;
  logic [DEPTH-1:0] vld_r;
  logic             rd_vld_r;

  // entries never written read back as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (wr_en) vld_r[addr] <= 1'b1;
      if (rd_en) rd_vld_r <= vld_r[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem_r[addr] <= wdata;
    if (rd_en) rd_data_r <= mem_r[addr];
  end

  assign rdata = rd_vld_r ? rd_data_r : '0;

endmodule

// File: rtl/core/tefr_ctrl.sv
`include "assert_macros.svh"

module tefr_ctrl #(
  parameter int ERROR_COUNT = 32,
  parameter int IW          = 5
) (
  input  logic                   clk,
  input  logic                   rst_n,
  tefr_in_if.sink                in_if,
  tefr_out_if.source             out_if,
  input  logic [ERROR_COUNT-1:0] crit_mask,
  input  logic [ERROR_COUNT-1:0] ign_mask,
  output tefr_pkg::mem_ctl_t     mem_ctl,
  output logic [IW-1:0]          mem_addr,
  output tefr_pkg::rec_t         mem_wdata,
  input  tefr_pkg::rec_t         set_rdata,
  input  tefr_pkg::rec_t         clr_rdata
);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_UPD   = 5'b00010,
    ST_READ  = 5'b00100,
    ST_RESP  = 5'b01000,
    ST_SWEEP = 5'b10000
  } state_t;

  typedef struct packed {
    logic                               error_set;
    logic                               current_state;
    logic [tefr_pkg::MODULE_W-1:0]      current_module;
    logic [tefr_pkg::STAMP_W-1:0]       current_time_stamp;
    logic [tefr_pkg::STAMP_W-1:0]       current_age;
    logic                               previous_state;
    logic [tefr_pkg::MODULE_W-1:0]      previous_module;
    logic [tefr_pkg::STAMP_W-1:0]       previous_time_stamp;
    logic [tefr_pkg::STAMP_W-1:0]       previous_age;
    logic                               is_enabled;
    logic                               is_critical;
    logic [tefr_pkg::FLAGS_W-1:0]       all_flags;
  } rsp_t;

  state_t                         state_r, state_nxt;
  logic [ERROR_COUNT-1:0]         flags_r, flags_nxt;
  logic [IW-1:0]                  cnt_r, cnt_nxt;
  logic                           out_vld_r, out_vld_nxt;
  rsp_t                           out_r, out_nxt;

  tefr_pkg::op_t                  op_r;
  logic                           idx_ok_r;
  logic [IW-1:0]                  idx_r;
  logic                           ns_r;
  logic [tefr_pkg::MODULE_W-1:0]  mod_r;
  logic [tefr_pkg::STAMP_W-1:0]   time_r;

  logic                           accept;
  logic                           flag_sel;
  logic                           det;
  tefr_pkg::rec_t                 cur, prv;
  rsp_t                           rsp;

  assign in_if.ready = (state_r == ST_IDLE);
  assign accept      = in_if.valid && in_if.ready;

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r     <= tefr_pkg::op_t'(in_if.operation);
      idx_ok_r <= in_if.error_index < tefr_pkg::INDEX_W'(ERROR_COUNT);
      idx_r    <= in_if.error_index[IW-1:0];
      ns_r     <= in_if.new_state;
      mod_r    <= in_if.caller_module;
      time_r   <= in_if.current_time;
    end
  end

  // response fields, valid while in ST_RESP (read data is held)
  always_comb begin
    flag_sel = flags_r[idx_r];
    det      = (op_r == tefr_pkg::OP_DETAILS) && idx_ok_r;
    cur      = flag_sel ? set_rdata : clr_rdata;
    prv      = flag_sel ? clr_rdata : set_rdata;
    rsp      = '0;
    rsp.all_flags = tefr_pkg::FLAGS_W'(flags_r);
    if (op_r == tefr_pkg::OP_SUMMARY) begin
      rsp.error_set   = |flags_r;
      rsp.is_critical = |(flags_r & crit_mask);
    end else if (det) begin
      rsp.error_set           = flag_sel;
      rsp.current_state       = cur.state;
      rsp.current_module      = cur.module_id;
      rsp.current_time_stamp  = cur.stamp;
      rsp.current_age         = time_r - cur.stamp;
      rsp.previous_state      = prv.state;
      rsp.previous_module     = prv.module_id;
      rsp.previous_time_stamp = prv.stamp;
      rsp.previous_age        = time_r - prv.stamp;
      rsp.is_enabled          = !ign_mask[idx_r];
      rsp.is_critical         = crit_mask[idx_r];
    end
  end

  always_comb begin
    state_nxt   = state_r;
    flags_nxt   = flags_r;
    cnt_nxt     = cnt_r;
    out_nxt     = out_r;
    out_vld_nxt = out_vld_r && !out_if.ready;
    mem_ctl     = '0;
    mem_addr    = (state_r == ST_SWEEP) ? cnt_r : idx_r;
    mem_wdata   = '{stamp: time_r, module_id: mod_r, state: 1'b0};

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (tefr_pkg::op_t'(in_if.operation))
            tefr_pkg::OP_SET_CLR: state_nxt = ST_UPD;
            tefr_pkg::OP_DETAILS: state_nxt = ST_READ;
            tefr_pkg::OP_CLR_ALL: begin
              state_nxt = ST_SWEEP;
              cnt_nxt   = '0;
            end
            tefr_pkg::OP_SUMMARY: state_nxt = ST_RESP;
            default: state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_UPD: begin
        if (idx_ok_r) begin
          if (ns_r && !flags_r[idx_r] && !ign_mask[idx_r]) begin
            flags_nxt[idx_r] = 1'b1;
            mem_ctl.set_wr   = 1'b1;
            mem_wdata.state  = 1'b1;
          end else if (!ns_r && flags_r[idx_r]) begin
            flags_nxt[idx_r] = 1'b0;
            mem_ctl.clr_wr   = 1'b1;
          end
        end
        state_nxt = ST_IDLE;
      end
      ST_READ: begin
        mem_ctl.rd_en = idx_ok_r;
        state_nxt     = ST_RESP;
      end
      ST_RESP: begin
        if (!out_vld_r || out_if.ready) begin
          out_nxt     = rsp;
          out_vld_nxt = 1'b1;
          state_nxt   = ST_IDLE;
        end
      end
      ST_SWEEP: begin
        if (flags_r[cnt_r]) begin
          flags_nxt[cnt_r] = 1'b0;
          mem_ctl.clr_wr   = 1'b1;
        end
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == IW'(ERROR_COUNT - 1)) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      flags_r   <= '0;
      cnt_r     <= '0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      flags_r   <= flags_nxt;
      cnt_r     <= cnt_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_if.valid               = out_vld_r;
  assign out_if.error_set           = out_r.error_set;
  assign out_if.current_state       = out_r.current_state;
  assign out_if.current_module      = out_r.current_module;
  assign out_if.current_time_stamp  = out_r.current_time_stamp;
  assign out_if.current_age         = out_r.current_age;
  assign out_if.previous_state      = out_r.previous_state;
  assign out_if.previous_module     = out_r.previous_module;
  assign out_if.previous_time_stamp = out_r.previous_time_stamp;
  assign out_if.previous_age        = out_r.previous_age;
  assign out_if.is_enabled          = out_r.is_enabled;
  assign out_if.is_critical         = out_r.is_critical;
  assign out_if.all_flags           = out_r.all_flags;

  `TEFR_ASSERT_IMP(a_no_rd_wr_overlap, clk, rst_n, mem_ctl.rd_en,
                   !mem_ctl.set_wr && !mem_ctl.clr_wr)
  `TEFR_ASSERT_IMP(a_set_wr_only_upd, clk, rst_n, mem_ctl.set_wr,
                   state_r == ST_UPD && ns_r && idx_ok_r)
  `TEFR_ASSERT_NXT(a_set_adds_flag, clk, rst_n, mem_ctl.set_wr,
                   $countones(flags_r) == $past($countones(flags_r)) + 1)
  `TEFR_ASSERT_NXT(a_sweep_clears, clk, rst_n,
                   state_r == ST_SWEEP && state_nxt == ST_IDLE, flags_r == '0)

endmodule

// File: rtl/core/timestamped_error_flag_recorder_core.sv
// Channel  Dir  Handshake      Payload
// in_if    in   valid/ready    operation, error_index, new_state, caller_module, current_time
// out_if   out  valid/ready    details or summary of the flags and records
// cfg_*    in   cfg_wr_en      cfg_index selects critical_mask or ignore_mask, cfg_data
//
// Set/clear passes through ST_UPD, a summary query through ST_RESP and a details query through
// ST_READ then ST_RESP (plus any wait on out_if); clear-all walks every flag index in ST_SWEEP,
// writing the clear record memory for each flag that is set. Set and clear records sit in two
// single-port memories with a registered read port. Synchronous reset clears flags, masks and
// per-entry valid bits; unwritten records read as zero, so there is no clearing pass.
// A new transaction is taken while a result waits in the output register.
module timestamped_error_flag_recorder_core #(
  parameter int ERROR_COUNT = 32
) (
  input  logic                              clk,
  input  logic                              rst_n,
  tefr_in_if.sink                           in_if,
  tefr_out_if.source                        out_if,
  input  logic                              cfg_wr_en,
  input  logic [tefr_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [tefr_pkg::FLAGS_W-1:0]      cfg_data
);

  localparam int IW = (ERROR_COUNT > 1) ? $clog2(ERROR_COUNT) : 1;

  logic [tefr_pkg::FLAGS_W-1:0] crit_r;
  logic [tefr_pkg::FLAGS_W-1:0] ign_r;

  tefr_pkg::mem_ctl_t mem_ctl;
  logic [IW-1:0]      mem_addr;
  tefr_pkg::rec_t     mem_wdata;
  tefr_pkg::rec_t     set_rdata;
  tefr_pkg::rec_t     clr_rdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crit_r <= '0;
      ign_r  <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        tefr_pkg::CFG_CRITICAL: crit_r <= cfg_data;
        tefr_pkg::CFG_IGNORE:   ign_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  tefr_ctrl #(
    .ERROR_COUNT (ERROR_COUNT),
    .IW          (IW)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (in_if),
    .out_if    (out_if),
    .crit_mask (crit_r[ERROR_COUNT-1:0]),
    .ign_mask  (ign_r[ERROR_COUNT-1:0]),
    .mem_ctl   (mem_ctl),
    .mem_addr  (mem_addr),
    .mem_wdata (mem_wdata),
    .set_rdata (set_rdata),
    .clr_rdata (clr_rdata)
  );

  tefr_rec_mem #(
    .DEPTH (ERROR_COUNT),
    .AW    (IW)
  ) u_set_mem (
    .clk   (clk),
    .rst_n (rst_n),
    .wr_en (mem_ctl.set_wr),
    .rd_en (mem_ctl.rd_en),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (set_rdata)
  );

  tefr_rec_mem #(
    .DEPTH (ERROR_COUNT),
    .AW    (IW)
  ) u_clr_mem (
    .clk   (clk),
    .rst_n (rst_n),
    .wr_en (mem_ctl.clr_wr),
    .rd_en (mem_ctl.rd_en),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (clr_rdata)
  );

endmodule

// File: bench/timestamped_error_flag_recorder_core_tb.sv
`timescale 1ns / 1ps

module timestamped_error_flag_recorder_core_tb;

  localparam int ERROR_COUNT = 32;
  // clear-all walks every record entry, so allow that much after the last result
  localparam int SETTLE_CYCLES = ERROR_COUNT + 8;

  typedef struct packed {
    logic        error_set;
    logic        current_state;
    logic [15:0] current_module;
    logic [31:0] current_time_stamp;
    logic [31:0] current_age;
    logic        previous_state;
    logic [15:0] previous_module;
    logic [31:0] previous_time_stamp;
    logic [31:0] previous_age;
    logic        is_enabled;
    logic        is_critical;
    logic [31:0] all_flags;
  } flag_report_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_wr_en;
  logic [tefr_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [tefr_pkg::FLAGS_W-1:0] cfg_data;

  tefr_in_if in_ch ();
  tefr_out_if out_ch ();

  timestamped_error_flag_recorder_core #(
    .ERROR_COUNT(ERROR_COUNT)
  ) uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_if(in_ch),
    .out_if(out_ch),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // tracked copy of the recorder
  logic [31:0] flag_word;
  logic [31:0] crit_mask;
  logic [31:0] ignore_mask;
  tefr_pkg::rec_t set_log [ERROR_COUNT];
  tefr_pkg::rec_t clear_log [ERROR_COUNT];

  flag_report_t pending_reports[$];
  int mismatch_count = 0;
  int src_mode = 0;
  int sink_mode = 0;
  int sink_hold = 0;
  int ready_stall = 0;

  // 0: never idle, 1: uniform 0..16, else mostly back to back
  function automatic int draw_delay(input int mode);
    case (mode)
      0: return 0;
      1: return $urandom_range(16);
      default: return ($urandom_range(7) == 0) ? $urandom_range(16) : 0;
    endcase
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatch_count++;
    $display("%0t ns: %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want)
      report_mismatch(name, got, want);
  endtask

  task automatic retire_flag(input int i, input logic [15:0] mod, input logic [31:0] now);
    if (flag_word[i]) begin
      flag_word[i] = 1'b0;
      clear_log[i] = '{stamp: now, module_id: mod, state: 1'b0};
    end
  endtask

  task automatic track_flag_request(input tefr_pkg::op_t op, input logic [15:0] idx,
                                    input logic ns, input logic [15:0] mod,
                                    input logic [31:0] now);
    flag_report_t r;
    tefr_pkg::rec_t cur;
    tefr_pkg::rec_t prv;
    logic hit;
    logic is_set;
    int i;
    int k;
    hit = idx < ERROR_COUNT;
    i = idx[4:0];
    r = '0;
    case (op)
      tefr_pkg::OP_SET_CLR: begin
        if (hit) begin
          if (ns) begin
            if (!flag_word[i] && !ignore_mask[i]) begin
              flag_word[i] = 1'b1;
              set_log[i] = '{stamp: now, module_id: mod, state: 1'b1};
            end
          end else begin
            retire_flag(i, mod, now);
          end
        end
      end
      tefr_pkg::OP_CLR_ALL: begin
        for (k = 0; k < ERROR_COUNT; k++)
          retire_flag(k, mod, now);
      end
      tefr_pkg::OP_SUMMARY: begin
        r.all_flags = flag_word;
        r.error_set = |flag_word;
        r.is_critical = |(flag_word & crit_mask);
        pending_reports.push_back(r);
      end
      default: begin
        r.all_flags = flag_word;
        if (hit) begin
          is_set = flag_word[i];
          cur = is_set ? set_log[i] : clear_log[i];
          prv = is_set ? clear_log[i] : set_log[i];
          r.error_set = is_set;
          r.current_state = cur.state;
          r.current_module = cur.module_id;
          r.current_time_stamp = cur.stamp;
          r.current_age = now - cur.stamp;
          r.previous_state = prv.state;
          r.previous_module = prv.module_id;
          r.previous_time_stamp = prv.stamp;
          r.previous_age = now - prv.stamp;
          r.is_enabled = !ignore_mask[i];
          r.is_critical = crit_mask[i];
        end
        pending_reports.push_back(r);
      end
    endcase
  endtask

  task automatic send_req(input tefr_pkg::op_t op, input logic [15:0] idx, input logic ns,
                          input logic [15:0] mod, input logic [31:0] now);
    int gap;
    gap = draw_delay(src_mode);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.operation <= op;
    in_ch.error_index <= idx;
    in_ch.new_state <= ns;
    in_ch.caller_module <= mod;
    in_ch.current_time <= now;
    @(posedge clk);
    while (in_ch.ready !== 1'b1) @(posedge clk);
    track_flag_request(op, idx, ns, mod, now);
  endtask

  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic load_masks(input logic [31:0] crit, input logic [31:0] ign);
    wait_idle();
    cfg_wr_en <= 1'b1;
    cfg_index <= tefr_pkg::CFG_CRITICAL;
    cfg_data <= crit;
    @(posedge clk);
    crit_mask = crit;
    cfg_index <= tefr_pkg::CFG_IGNORE;
    cfg_data <= ign;
    @(posedge clk);
    ignore_mask = ign;
    cfg_wr_en <= 1'b0;
  endtask

  function automatic tefr_pkg::op_t pick_op();
    int r;
    r = $urandom_range(99);
    if (r < 50) return tefr_pkg::OP_SET_CLR;
    else if (r < 78) return tefr_pkg::OP_DETAILS;
    else if (r < 92) return tefr_pkg::OP_SUMMARY;
    else return tefr_pkg::OP_CLR_ALL;
  endfunction

  function automatic logic [15:0] pick_index();
    int r;
    r = $urandom_range(99);
    if (r < 88) return 16'($urandom_range(ERROR_COUNT - 1));
    else if (r < 95) return 16'($urandom_range(16'hFFFF, ERROR_COUNT));
    else if (r < 98) return 16'hFFFF;
    else return 16'(ERROR_COUNT);
  endfunction

  task automatic test_after_reset();
    send_req(tefr_pkg::OP_SUMMARY, 16'd0, 1'b0, 16'd0, 32'd0);
    send_req(tefr_pkg::OP_DETAILS, 16'd31, 1'b0, 16'h1234, 32'hFFFF_FFFF);
  endtask

  task automatic test_set_clear();
    send_req(tefr_pkg::OP_SET_CLR, 16'd0, 1'b1, 16'hFFFF, 32'hFFFF_FFFF);
    send_req(tefr_pkg::OP_SET_CLR, 16'd31, 1'b1, 16'h0000, 32'd0);
    // already set: record must keep the first stamp
    send_req(tefr_pkg::OP_SET_CLR, 16'd0, 1'b1, 16'h0001, 32'd7);
    send_req(tefr_pkg::OP_DETAILS, 16'd0, 1'b0, 16'd0, 32'd5);
    send_req(tefr_pkg::OP_SET_CLR, 16'd31, 1'b0, 16'hAAAA, 32'h8000_0000);
    send_req(tefr_pkg::OP_SET_CLR, 16'd31, 1'b0, 16'h5555, 32'd1);
    send_req(tefr_pkg::OP_DETAILS, 16'd31, 1'b0, 16'd0, 32'h7FFF_FFFF);
    send_req(tefr_pkg::OP_SET_CLR, 16'hFFFF, 1'b1, 16'h00FF, 32'd9);
    send_req(tefr_pkg::OP_DETAILS, 16'hFFFF, 1'b0, 16'd0, 32'd10);
    send_req(tefr_pkg::OP_DETAILS, 16'd32, 1'b0, 16'd0, 32'd11);
    send_req(tefr_pkg::OP_SUMMARY, 16'd0, 1'b0, 16'd0, 32'd12);
  endtask

  task automatic test_masks();
    load_masks(32'h8000_0001, 32'hFFFF_FFFE);
    send_req(tefr_pkg::OP_SET_CLR, 16'd5, 1'b1, 16'h0F0F, 32'd100);
    send_req(tefr_pkg::OP_DETAILS, 16'd5, 1'b0, 16'd0, 32'd101);
    send_req(tefr_pkg::OP_DETAILS, 16'd0, 1'b0, 16'd0, 32'd102);
    send_req(tefr_pkg::OP_SET_CLR, 16'd0, 1'b0, 16'hF0F0, 32'd103);
    send_req(tefr_pkg::OP_SET_CLR, 16'd0, 1'b1, 16'h3C3C, 32'd104);
    send_req(tefr_pkg::OP_SUMMARY, 16'd0, 1'b0, 16'd0, 32'd105);
    load_masks(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    // clearing goes through even with every bit ignored
    send_req(tefr_pkg::OP_SET_CLR, 16'd1, 1'b1, 16'h1111, 32'd200);
    send_req(tefr_pkg::OP_SET_CLR, 16'd0, 1'b0, 16'h2222, 32'd201);
    send_req(tefr_pkg::OP_SUMMARY, 16'd0, 1'b0, 16'd0, 32'd202);
  endtask

  task automatic test_clear_all();
    load_masks(32'h0002_0000, 32'h0000_0000);
    send_req(tefr_pkg::OP_SET_CLR, 16'd3, 1'b1, 16'h0003, 32'd300);
    send_req(tefr_pkg::OP_SET_CLR, 16'd17, 1'b1, 16'h0017, 32'd310);
    send_req(tefr_pkg::OP_SET_CLR, 16'd30, 1'b1, 16'h0030, 32'd320);
    send_req(tefr_pkg::OP_CLR_ALL, 16'd0, 1'b0, 16'hBEEF, 32'd1000);
    send_req(tefr_pkg::OP_SUMMARY, 16'd0, 1'b0, 16'd0, 32'd1001);
    send_req(tefr_pkg::OP_DETAILS, 16'd17, 1'b0, 16'd0, 32'd1002);
  endtask

  // sink holds off while the source keeps offering queries
  task automatic test_output_backpressure();
    int n;
    src_mode = 0;
    sink_hold = 400;
    for (n = 0; n < 48; n++)
      send_req((n % 2) ? tefr_pkg::OP_SUMMARY : tefr_pkg::OP_DETAILS, 16'(n % 32), 1'b0,
               16'(n), 32'(5000 + n));
  endtask

  task automatic test_random_traffic();
    int phase;
    int n;
    logic [31:0] crit;
    logic [31:0] ign;
    logic [31:0] clock_now;
    clock_now = $urandom();
    for (phase = 0; phase < 8; phase++) begin
      case (phase)
        0: begin
          crit = '0;
          ign = '0;
        end
        1: begin
          crit = '1;
          ign = '0;
        end
        2: begin
          crit = '1;
          ign = '1;
        end
        3: begin
          crit = '0;
          ign = $urandom() & $urandom();
        end
        default: begin
          crit = $urandom();
          ign = $urandom() & $urandom();
        end
      endcase
      load_masks(crit, ign);
      for (n = 0; n < 200; n++) begin
        if (n % 50 == 0) begin
          src_mode = $urandom_range(2);
          sink_mode = $urandom_range(2);
        end
        if ($urandom_range(31) == 0)
          clock_now = $urandom();
        else
          clock_now += $urandom_range(40);
        send_req(pick_op(), pick_index(), $urandom_range(99) < 55, 16'($urandom()),
                 clock_now);
      end
    end
  endtask

  // result sink: per-transaction stall plus an optional long hold
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      ready_stall = 0;
    end else begin
      if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
        ready_stall = draw_delay(sink_mode);
      if (sink_hold > 0) begin
        sink_hold--;
        out_ch.ready <= 1'b0;
      end else if (ready_stall > 0) begin
        ready_stall--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : report_check
    flag_report_t want;
    if (rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (pending_reports.size() == 0) begin
        report_mismatch("result with no transaction pending", 32'd0, 32'd0);
      end else begin
        want = pending_reports.pop_front();
        check_field("error_set", out_ch.error_set, want.error_set);
        check_field("current_state", out_ch.current_state, want.current_state);
        check_field("current_module", out_ch.current_module, want.current_module);
        check_field("current_time_stamp", out_ch.current_time_stamp,
                    want.current_time_stamp);
        check_field("current_age", out_ch.current_age, want.current_age);
        check_field("previous_state", out_ch.previous_state, want.previous_state);
        check_field("previous_module", out_ch.previous_module, want.previous_module);
        check_field("previous_time_stamp", out_ch.previous_time_stamp,
                    want.previous_time_stamp);
        check_field("previous_age", out_ch.previous_age, want.previous_age);
        check_field("is_enabled", out_ch.is_enabled, want.is_enabled);
        check_field("is_critical", out_ch.is_critical, want.is_critical);
        check_field("all_flags", out_ch.all_flags, want.all_flags);
      end
    end
  end

  initial begin
    #10_000_000;
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    int i;
    rst_n = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_index = tefr_pkg::CFG_CRITICAL;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.operation = tefr_pkg::OP_SET_CLR;
    in_ch.error_index = '0;
    in_ch.new_state = 1'b0;
    in_ch.caller_module = '0;
    in_ch.current_time = '0;
    out_ch.ready = 1'b0;
    flag_word = '0;
    crit_mask = '0;
    ignore_mask = '0;
    for (i = 0; i < ERROR_COUNT; i++) begin
      set_log[i] = '0;
      clear_log[i] = '0;
    end
    src_mode = 1;
    sink_mode = 2;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    test_after_reset();
    test_set_clear();
    test_masks();
    test_clear_all();
    test_output_backpressure();
    test_random_traffic();

    wait_idle();
    if (mismatch_count == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
